[hdl/imm_pkg.sv]
package imm_pkg;

    localparam int DATA_W = 32;
    localparam int IDX_W  = 3;
    localparam int CFG_W  = 4;
    localparam int ADDR_W = 4;
    localparam int OUT_W  = 40;

    typedef enum logic [1:0] {
        REG_ROWS_A    = 2'd0,
        REG_INNER_LEN = 2'd1,
        REG_COLS_B    = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic              v;
        logic [IDX_W-1:0]  t;
        logic [DATA_W-1:0] a;
    } t_link;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  j;
        logic [IDX_W-1:0]  t;
        logic [DATA_W-1:0] data;
    } t_bwr;

endpackage

[hdl/imm_cell.sv]
module imm_cell
    import imm_pkg::*;
#(
    parameter int MAX_DIM  = 8,
    parameter int CELL_IDX = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_bwr              i_bwr,
    input  t_link             i_link,
    output t_link             o_link,
    output logic [DATA_W-1:0] o_acc
);

    localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DEPTH = 1 << IW;

    logic [DATA_W-1:0] r_bcol [DEPTH];
    logic [DATA_W-1:0] r_acc;
    logic [DATA_W-1:0] n_acc;
    logic [DATA_W-1:0] w_prod;
    logic              r_v;
    logic [IDX_W-1:0]  r_t;
    logic [DATA_W-1:0] r_a;

    // hold this cell's column of B
    always_ff @(posedge i_clk) begin
        if (i_bwr.en && (i_bwr.j == IDX_W'(CELL_IDX))) begin
            r_bcol[i_bwr.t[IW-1:0]] <= i_bwr.data;
        end
    end

    assign w_prod = i_link.a * r_bcol[i_link.t[IW-1:0]];

    always_comb begin
        n_acc = r_acc;
        if (i_link.v) begin
            n_acc = ((i_link.t == '0) ? '0 : r_acc) + w_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_t   <= i_link.t;
        r_a   <= i_link.a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= i_link.v;
        end
    end

    assign o_link = '{v: r_v, t: r_t, a: r_a};
    assign o_acc  = r_acc;

endmodule

[hdl/integer_matrix_multiply_top.sv]
// Load: one element beat per cycle, rows_a*inner_len + inner_len*cols_b beats.
// Compute: per product row, the ISSUE state feeds inner_len elements of A into the cell chain,
//   DRAIN waits until the chain is empty, then cols_b output beats (one per cycle while i_m_tready is high).
// First result follows the last B beat after the ISSUE and DRAIN states.
// Reset (synchronous, active low): dimensions to 1, load restarts; stores undefined.
module integer_matrix_multiply_top
    import imm_pkg::*;
#(
    parameter int MAX_DIM = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [DATA_W-1:0] i_s_tdata,   // element_value[31:0]
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [OUT_W-1:0]  o_m_tdata,   // product_value[31:0], out_row[34:32], out_col[37:35]
    output logic              o_m_tlast,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int ADEPTH = 1 << (2 * IW);

    typedef enum logic [3:0] {
        S_LOAD  = 4'b0001,
        S_ISSUE = 4'b0010,
        S_DRAIN = 4'b0100,
        S_OUT   = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [CFG_W-1:0] r_rows, r_inner, r_cols;
    logic [CFG_W-1:0] w_r_eff, w_k_eff, w_c_eff;
    logic [IW-1:0]    w_rm1, w_km1, w_cm1;

    logic [IW-1:0] r_la_i, n_la_i, r_la_t, n_la_t;
    logic [IW-1:0] r_lb_t, n_lb_t, r_lb_j, n_lb_j;
    logic          r_phase_b, n_phase_b;
    logic [IW-1:0] r_ci, n_ci, r_ct, n_ct, r_oj, n_oj;

    logic [DATA_W-1:0] r_mem_a [ADEPTH];
    logic [DATA_W-1:0] r_rd_a;
    logic [IW-1:0]     r_rd_t;
    logic              r_rd_v;

    logic w_cfg_wr, w_in_acc, w_out_acc, w_issue, w_chain_busy;
    t_bwr w_bwr;

    t_link             w_link [MAX_DIM+1];
    logic [DATA_W-1:0] w_acc  [MAX_DIM];
    logic [MAX_DIM-1:0] w_cell_v;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows  <= CFG_W'(1);
            r_inner <= CFG_W'(1);
            r_cols  <= CFG_W'(1);
        end else if (w_cfg_wr) begin
            case (t_reg_idx'(paddr[3:2]))
                REG_ROWS_A:    r_rows  <= pwdata[CFG_W-1:0];
                REG_INNER_LEN: r_inner <= pwdata[CFG_W-1:0];
                REG_COLS_B:    r_cols  <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[3:2]))
            REG_ROWS_A:    prdata = 32'(r_rows);
            REG_INNER_LEN: prdata = 32'(r_inner);
            REG_COLS_B:    prdata = 32'(r_cols);
            default:       prdata = '0;
        endcase
    end

    // clamp dimensions to 1..MAX_DIM
    assign w_r_eff = (r_rows == '0) ? CFG_W'(1) :
                     (r_rows > CFG_W'(MAX_DIM)) ? CFG_W'(MAX_DIM) : r_rows;
    assign w_k_eff = (r_inner == '0) ? CFG_W'(1) :
                     (r_inner > CFG_W'(MAX_DIM)) ? CFG_W'(MAX_DIM) : r_inner;
    assign w_c_eff = (r_cols == '0) ? CFG_W'(1) :
                     (r_cols > CFG_W'(MAX_DIM)) ? CFG_W'(MAX_DIM) : r_cols;
    assign w_rm1 = IW'(w_r_eff - CFG_W'(1));
    assign w_km1 = IW'(w_k_eff - CFG_W'(1));
    assign w_cm1 = IW'(w_c_eff - CFG_W'(1));

    assign o_s_tready = (r_state == S_LOAD);
    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = (r_state == S_OUT);
    assign w_out_acc  = o_m_tvalid && i_m_tready;
    assign w_issue    = (r_state == S_ISSUE);

    assign w_chain_busy = r_rd_v || (|w_cell_v);

    always_comb begin
        n_state   = r_state;
        n_la_i    = r_la_i;
        n_la_t    = r_la_t;
        n_lb_t    = r_lb_t;
        n_lb_j    = r_lb_j;
        n_phase_b = r_phase_b;
        n_ci      = r_ci;
        n_ct      = r_ct;
        n_oj      = r_oj;
        unique case (r_state)
            S_LOAD: begin
                if (w_in_acc && !r_phase_b) begin
                    if (r_la_t == w_km1) begin
                        n_la_t = '0;
                        if (r_la_i == w_rm1) begin
                            n_la_i    = '0;
                            n_phase_b = 1'b1;
                        end else begin
                            n_la_i = r_la_i + 1'b1;
                        end
                    end else begin
                        n_la_t = r_la_t + 1'b1;
                    end
                end else if (w_in_acc) begin
                    if (r_lb_j == w_cm1) begin
                        n_lb_j = '0;
                        if (r_lb_t == w_km1) begin
                            n_lb_t    = '0;
                            n_phase_b = 1'b0;
                            n_ci      = '0;
                            n_ct      = '0;
                            n_state   = S_ISSUE;
                        end else begin
                            n_lb_t = r_lb_t + 1'b1;
                        end
                    end else begin
                        n_lb_j = r_lb_j + 1'b1;
                    end
                end
            end
            S_ISSUE: begin
                if (r_ct == w_km1) begin
                    n_ct    = '0;
                    n_state = S_DRAIN;
                end else begin
                    n_ct = r_ct + 1'b1;
                end
            end
            S_DRAIN: begin
                if (!w_chain_busy) begin
                    n_oj    = '0;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_acc) begin
                    if (r_oj == w_cm1) begin
                        n_oj = '0;
                        if (r_ci == w_rm1) begin
                            n_ci    = '0;
                            n_state = S_LOAD;
                        end else begin
                            n_ci    = r_ci + 1'b1;
                            n_ct    = '0;
                            n_state = S_ISSUE;
                        end
                    end else begin
                        n_oj = r_oj + 1'b1;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase
        if (w_cfg_wr &&
            (t_reg_idx'(paddr[3:2]) inside {REG_ROWS_A, REG_INNER_LEN, REG_COLS_B})) begin
            n_la_i    = '0;
            n_la_t    = '0;
            n_lb_t    = '0;
            n_lb_j    = '0;
            n_phase_b = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_la_i    <= '0;
            r_la_t    <= '0;
            r_lb_t    <= '0;
            r_lb_j    <= '0;
            r_phase_b <= 1'b0;
            r_ci      <= '0;
            r_ct      <= '0;
            r_oj      <= '0;
            r_rd_v    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_la_i    <= n_la_i;
            r_la_t    <= n_la_t;
            r_lb_t    <= n_lb_t;
            r_lb_j    <= n_lb_j;
            r_phase_b <= n_phase_b;
            r_ci      <= n_ci;
            r_ct      <= n_ct;
            r_oj      <= n_oj;
            r_rd_v    <= w_issue;
        end
    end

    // store of A, addressed by row and column
    always_ff @(posedge i_clk) begin
        if (w_in_acc && !r_phase_b) begin
            r_mem_a[{r_la_i, r_la_t}] <= i_s_tdata;
        end
        r_rd_a <= r_mem_a[{r_ci, r_ct}];
        r_rd_t <= r_ct;
    end

    assign w_bwr = '{en: w_in_acc && r_phase_b, j: IDX_W'(r_lb_j),
                     t: IDX_W'(r_lb_t), data: i_s_tdata};

    assign w_link[0] = '{v: r_rd_v, t: IDX_W'(r_rd_t), a: r_rd_a};

    for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
        imm_cell #(
            .MAX_DIM  (MAX_DIM),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_bwr   (w_bwr),
            .i_link  (w_link[g]),
            .o_link  (w_link[g+1]),
            .o_acc   (w_acc[g])
        );
        assign w_cell_v[g] = w_link[g+1].v;
    end

    assign o_m_tdata = {2'b00, 3'(r_oj), 3'(r_ci), w_acc[r_oj]};
    assign o_m_tlast = (r_ci == w_rm1) && (r_oj == w_cm1);

    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_s_tready)
        else $error("input ready while product beats pending");

    a_last_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_m_tlast) |=> o_s_tready)
        else $error("load not reopened after last product beat");

    a_read_in_compute: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_v |-> (r_state == S_ISSUE || r_state == S_DRAIN))
        else $error("chain fed outside compute");

    a_no_out_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !w_chain_busy)
        else $error("product shown while chain busy");

endmodule
